// ===== design/ahd_pkg.sv =====
package ahd_pkg;

    localparam logic [1:0] KIND_HEADER   = 2'd0;
    localparam logic [1:0] KIND_COMPLETE = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD  = 2'd2;
    localparam logic [1:0] KIND_ERROR    = 2'd3;

    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic [1:0] REG_HDR_LEN_V1   = 2'd0;
    localparam logic [1:0] REG_HDR_LEN_V2   = 2'd1;
    localparam logic [1:0] REG_MAX_FRAME_SZ = 2'd2;

    localparam logic [7:0] SYNC_BYTE   = 8'h55;
    localparam logic [7:0] SYNC_ZERO   = 8'h00;
    localparam logic [7:0] VER_BYTE_V1 = 8'h01;
    localparam logic [7:0] VER_BYTE_V2 = 8'h02;
    localparam logic [1:0] VER_1       = 2'd1;

    localparam logic [5:0] SYNC_PREFIX_LEN = 6'd4;
    localparam logic [5:0] SYNC_ZERO_IDX   = 6'd2;
    localparam logic [5:0] SIZE_END_IDX    = 6'd8;
    localparam logic [5:0] TIME_END_IDX    = 6'd16;
    localparam logic [5:0] HDR_LEN_MIN     = 6'd16;
    localparam logic [5:0] HDR_LEN_MAX     = 6'd32;

    localparam logic [5:0]  RST_HDR_LEN_V1   = 6'd16;
    localparam logic [5:0]  RST_HDR_LEN_V2   = 6'd20;
    localparam logic [31:0] RST_MAX_FRAME_SZ = 32'd4096;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic        last;
        logic [31:0] body_len;
        logic [63:0] timestamp;
        logic [31:0] stream_offset;
        logic [1:0]  version;
        logic        size_warning;
    } out_beat_t;

    typedef struct packed {
        logic [5:0]  header_len_v1;
        logic [5:0]  header_len_v2;
        logic [31:0] max_body_len;
    } ahd_cfg_t;

endpackage

// ===== design/ahd_parser.sv =====
module ahd_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  ahd_pkg::ahd_cfg_t cfg,
    input  logic              fire,
    input  ahd_pkg::in_beat_t beat,
    output ahd_pkg::out_beat_t res
);
    import ahd_pkg::*;

    logic        in_body_reg,   in_body_next;
    logic [5:0]  hdr_idx_reg,   hdr_idx_next;
    logic [1:0]  hdr_ver_reg,   hdr_ver_next;
    logic [31:0] size_reg,      size_next;
    logic [63:0] time_reg,      time_next;
    logic [31:0] frame_off_reg, frame_off_next;
    logic [31:0] offset_reg,    offset_next;

    logic [5:0]  hlen_raw;
    logic [5:0]  hlen;
    logic [5:0]  idx_inc;
    logic [7:0]  want;
    logic [31:0] size_new;
    logic [63:0] time_new;

    always_comb
    begin
        hlen_raw = (hdr_ver_reg == VER_1) ? cfg.header_len_v1 : cfg.header_len_v2;
        if (hlen_raw < HDR_LEN_MIN)
            hlen = HDR_LEN_MIN;
        else if (hlen_raw > HDR_LEN_MAX)
            hlen = HDR_LEN_MAX;
        else
            hlen = hlen_raw;
    end

    always_comb
    begin
        idx_inc  = hdr_idx_reg + 6'd1;
        want     = (hdr_idx_reg == SYNC_ZERO_IDX) ? SYNC_ZERO : SYNC_BYTE;
        size_new = size_reg;
        time_new = time_reg;
        if (hdr_idx_reg < SIZE_END_IDX)
            size_new = {size_reg[23:0], beat.data_byte};
        else if (hdr_idx_reg < TIME_END_IDX)
            time_new = {time_reg[55:0], beat.data_byte};

        res               = '0;
        res.stream_offset = offset_reg;

        in_body_next   = in_body_reg;
        hdr_idx_next   = hdr_idx_reg;
        hdr_ver_next   = hdr_ver_reg;
        size_next      = size_reg;
        time_next      = time_reg;
        frame_off_next = frame_off_reg;
        offset_next    = offset_reg;

        if (beat.cmd == CMD_FLUSH)
        begin
            in_body_next      = 1'b0;
            hdr_idx_next      = '0;
            hdr_ver_next      = '0;
            size_next         = '0;
            time_next         = '0;
            offset_next       = '0;
            res.kind          = KIND_HEADER;
            res.stream_offset = '0;
        end
        else if (in_body_reg)
        begin
            res.kind          = KIND_PAYLOAD;
            res.payload_byte  = beat.data_byte;
            res.stream_offset = frame_off_reg;
            size_next         = size_reg - 32'd1;
            if (size_reg == 32'd1)
            begin
                res.last     = 1'b1;
                in_body_next = 1'b0;
                hdr_idx_next = '0;
                hdr_ver_next = '0;
                size_next    = '0;
                time_next    = '0;
            end
        end
        else if (hdr_idx_reg < SYNC_PREFIX_LEN - 6'd1)
        begin
            if (beat.data_byte != want)
            begin
                res.kind     = KIND_ERROR;
                hdr_idx_next = '0;
                hdr_ver_next = '0;
                size_next    = '0;
                time_next    = '0;
            end
            else
                hdr_idx_next = idx_inc;
        end
        else if (hdr_idx_reg == SYNC_PREFIX_LEN - 6'd1)
        begin
            if (beat.data_byte != VER_BYTE_V1 && beat.data_byte != VER_BYTE_V2)
            begin
                res.kind     = KIND_ERROR;
                hdr_idx_next = '0;
                hdr_ver_next = '0;
                size_next    = '0;
                time_next    = '0;
            end
            else
            begin
                hdr_ver_next = beat.data_byte[1:0];
                hdr_idx_next = idx_inc;
            end
        end
        else
        begin
            size_next    = size_new;
            time_next    = time_new;
            hdr_idx_next = idx_inc;
            if (idx_inc >= hlen)
            begin
                res.kind         = KIND_COMPLETE;
                res.body_len     = size_new;
                res.timestamp    = time_new;
                res.version      = hdr_ver_reg;
                res.size_warning = (size_new == 32'd0) || (size_new > cfg.max_body_len);
                offset_next      = offset_reg + size_new;
                frame_off_next   = offset_reg;
                hdr_idx_next     = '0;
                if (size_new == 32'd0)
                begin
                    hdr_ver_next = '0;
                    time_next    = '0;
                end
                else
                    in_body_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_body_reg   <= 1'b0;
            hdr_idx_reg   <= '0;
            hdr_ver_reg   <= '0;
            size_reg      <= '0;
            time_reg      <= '0;
            frame_off_reg <= '0;
            offset_reg    <= '0;
        end
        else if (fire)
        begin
            in_body_reg   <= in_body_next;
            hdr_idx_reg   <= hdr_idx_next;
            hdr_ver_reg   <= hdr_ver_next;
            size_reg      <= size_next;
            time_reg      <= time_next;
            frame_off_reg <= frame_off_next;
            offset_reg    <= offset_next;
        end
    end

`ifndef SYNTHESIS
    a_body_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        in_body_reg |-> size_reg != 32'd0)
        else $error("body active with zero bytes remaining");

    a_body_idx_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_body_reg |-> hdr_idx_reg == 6'd0)
        else $error("header index not cleared in body");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_idx_reg < HDR_LEN_MAX)
        else $error("header index past maximum header length");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && beat.cmd == CMD_FLUSH) |=> (offset_reg == 32'd0 && !in_body_reg))
        else $error("flush did not clear state");
`endif

endmodule

// ===== design/ahd_skid.sv =====
module ahd_skid (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  ahd_pkg::out_beat_t  res,
    output logic                ready,
    output logic                out_valid,
    input  logic                out_ready,
    output ahd_pkg::out_beat_t  out_data
);
    import ahd_pkg::*;

    logic      out_valid_reg;
    logic      skid_valid_reg;
    out_beat_t out_data_reg;
    out_beat_t skid_data_reg;

    assign ready     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= fire;
        end
        else if (fire)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (fire)
                out_data_reg <= res;
        end
        else if (fire)
            skid_data_reg <= res;
    end

endmodule

// ===== design/avsync_header_deframer_core.sv =====
// An accepted beat is registered to out_data/out_valid, or held in the skid while out is stalled.
// Throughput: one stream byte or flush per cycle while in_ready is high; a 2-entry output
// register/skid pair decouples in_ready from out_ready so the parse loop never stalls on its own.
// Reset (async, active low): parse state and running offset cleared, header hunt armed,
// output empty, header_len_v1/v2 = 16/20, max body length = 4096.
module avsync_header_deframer_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  ahd_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ahd_pkg::out_beat_t out_data
);
    import ahd_pkg::*;

    ahd_cfg_t  cfg_reg;
    out_beat_t res;
    logic      fire;

    assign fire = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_len_v1 <= RST_HDR_LEN_V1;
            cfg_reg.header_len_v2 <= RST_HDR_LEN_V2;
            cfg_reg.max_body_len  <= RST_MAX_FRAME_SZ;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HDR_LEN_V1:   cfg_reg.header_len_v1 <= cfg_data[5:0];
                REG_HDR_LEN_V2:   cfg_reg.header_len_v2 <= cfg_data[5:0];
                REG_MAX_FRAME_SZ: cfg_reg.max_body_len  <= cfg_data;
                default:          ;
            endcase
        end
    end

    ahd_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .fire  (fire),
        .beat  (in_data),
        .res   (res)
    );

    ahd_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .res       (res),
        .ready     (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
